### rtl/hslsat_pkg.sv
// shared types and constants for the hsl saturation set pipeline
// no dependencies; imported by the interfaces and every module
`timescale 1ns / 1ps

package hslsat_pkg;

    localparam int CHAN_W = 8;
    localparam int SAT_W  = 9;
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    localparam logic [SAT_W-1:0] SAT_ONE = 9'd256;

    // register index taken from paddr[2]
    localparam logic REG_TARGET_SAT = 1'b0;

    // 60-degree hue sectors, red to yellow first
    typedef enum logic [2:0] {
        SECT_RY = 3'd0,
        SECT_YG = 3'd1,
        SECT_GC = 3'd2,
        SECT_CB = 3'd3,
        SECT_BM = 3'd4,
        SECT_MR = 3'd5
    } sector_t;

    typedef struct packed {
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
    } pix_t;

    // hue and lightness terms leaving the analyse stages
    typedef struct packed {
        logic [8:0]  sum;
        logic [15:0] ks;
        logic [7:0]  dd;
        logic [7:0]  fnum;
        sector_t     sector;
    } hue_t;

    // terms leaving the divide stages
    typedef struct packed {
        logic [8:0]  sum;
        logic [15:0] ks;
        logic [16:0] part;
        sector_t     sector;
    } comp_t;

endpackage

### rtl/hslsat_in_if.sv
// input pixel channel: valid/ready handshake with bgr payload
// depends on hslsat_pkg
`timescale 1ns / 1ps

interface hslsat_in_if import hslsat_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] in_blue;
    logic [CHAN_W-1:0] in_green;
    logic [CHAN_W-1:0] in_red;

    modport source (output valid, output in_blue, output in_green, output in_red,
                    input ready);
    modport sink   (input valid, input in_blue, input in_green, input in_red,
                    output ready);
endinterface

### rtl/hslsat_out_if.sv
// output pixel channel: valid/ready handshake with bgr payload
// depends on hslsat_pkg
`timescale 1ns / 1ps

interface hslsat_out_if import hslsat_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] out_blue;
    logic [CHAN_W-1:0] out_green;
    logic [CHAN_W-1:0] out_red;

    modport source (output valid, output out_blue, output out_green, output out_red,
                    input ready);
    modport sink   (input valid, input out_blue, input out_green, input out_red,
                    output ready);
endinterface

### rtl/hslsat_analyse.sv
// two pipeline stages: max/min, spread and hue numerator, then sector,
// sector fraction and chroma product k*s; depends on hslsat_pkg
`timescale 1ns / 1ps

module hslsat_analyse import hslsat_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [SAT_W-1:0] target_sat,
    input  logic             in_valid,
    output logic             in_ready,
    input  pix_t             in_pix,
    output logic             out_valid,
    input  logic             out_ready,
    output hue_t             out_hue
);

    logic        va_reg;
    logic        vb_reg;
    logic        adv_a;
    logic        adv_b;

    logic [8:0]  sum_a_reg, sum_a_next;
    logic [7:0]  dd_a_reg, dd_a_next;
    logic [10:0] p_a_reg, p_a_next;
    logic [8:0]  s_a_reg, s_a_next;
    hue_t        hue_reg, hue_next;

    logic [7:0]         mx, mn, d;
    logic signed [11:0] p_s, diff, d2, d4, d6;

    logic [10:0] m1, m2, m3, m4, m5, mult;
    logic [10:0] rem;
    logic [7:0]  k;

    assign adv_b    = !vb_reg || out_ready;
    assign adv_a    = !va_reg || adv_b;
    assign in_ready = adv_a;

    // stage a
    always_comb
    begin
        mx = in_pix.red;
        if (in_pix.green > mx)
        begin
            mx = in_pix.green;
        end
        if (in_pix.blue > mx)
        begin
            mx = in_pix.blue;
        end
        mn = in_pix.red;
        if (in_pix.green < mn)
        begin
            mn = in_pix.green;
        end
        if (in_pix.blue < mn)
        begin
            mn = in_pix.blue;
        end
        d  = mx - mn;
        d2 = $signed({3'b000, d, 1'b0});
        d4 = $signed({2'b00, d, 2'b00});
        d6 = d4 + d2;
        diff = 12'sd0;
        p_s  = 12'sd0;
        // red wins ties over green, green over blue
        if (d == 8'd0)
        begin
            p_s = 12'sd0;
        end
        else if (mx == in_pix.red)
        begin
            diff = $signed({4'b0000, in_pix.green}) - $signed({4'b0000, in_pix.blue});
            p_s  = (diff < 12'sd0) ? diff + d6 : diff;
        end
        else if (mx == in_pix.green)
        begin
            p_s = $signed({4'b0000, in_pix.blue}) - $signed({4'b0000, in_pix.red}) + d2;
        end
        else
        begin
            p_s = $signed({4'b0000, in_pix.red}) - $signed({4'b0000, in_pix.green}) + d4;
        end
        p_a_next   = p_s[10:0];
        dd_a_next  = (d == 8'd0) ? 8'd1 : d;
        sum_a_next = {1'b0, mx} + {1'b0, mn};
        s_a_next   = (target_sat > SAT_ONE) ? SAT_ONE : target_sat;
    end

    // stage b
    always_comb
    begin
        m1 = {3'b000, dd_a_reg};
        m2 = {2'b00, dd_a_reg, 1'b0};
        m3 = m1 + m2;
        m4 = {1'b0, dd_a_reg, 2'b00};
        m5 = m4 + m1;
        if (p_a_reg >= m5)
        begin
            hue_next.sector = SECT_MR;
            mult = m5;
        end
        else if (p_a_reg >= m4)
        begin
            hue_next.sector = SECT_BM;
            mult = m4;
        end
        else if (p_a_reg >= m3)
        begin
            hue_next.sector = SECT_CB;
            mult = m3;
        end
        else if (p_a_reg >= m2)
        begin
            hue_next.sector = SECT_GC;
            mult = m2;
        end
        else if (p_a_reg >= m1)
        begin
            hue_next.sector = SECT_YG;
            mult = m1;
        end
        else
        begin
            hue_next.sector = SECT_RY;
            mult = 11'd0;
        end
        rem = p_a_reg - mult;
        // falling edge of the sector ramp in odd sectors
        if (hue_next.sector inside {SECT_YG, SECT_CB, SECT_MR})
        begin
            hue_next.fnum = dd_a_reg - rem[7:0];
        end
        else
        begin
            hue_next.fnum = rem[7:0];
        end
        // chroma scale 255*(1 - |2l - 1|)
        k = (sum_a_reg >= 9'd255) ? 8'(9'd510 - sum_a_reg) : sum_a_reg[7:0];
        hue_next.ks  = 16'({8'd0, k} * {7'd0, s_a_reg});
        hue_next.sum = sum_a_reg;
        hue_next.dd  = dd_a_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else
        begin
            if (adv_a)
            begin
                va_reg <= in_valid;
            end
            if (adv_b)
            begin
                vb_reg <= va_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_a && in_valid)
        begin
            sum_a_reg <= sum_a_next;
            dd_a_reg  <= dd_a_next;
            p_a_reg   <= p_a_next;
            s_a_reg   <= s_a_next;
        end
        if (adv_b && va_reg)
        begin
            hue_reg <= hue_next;
        end
    end

    assign out_valid = vb_reg;
    assign out_hue   = hue_reg;

endmodule

### rtl/hslsat_divide.sv
// three pipeline stages: floor(2*k*s*fnum / dd) by reciprocal multiply,
// split into two partial products; depends on hslsat_pkg
`timescale 1ns / 1ps

module hslsat_divide import hslsat_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  hue_t  in_hue,
    output logic  out_valid,
    input  logic  out_ready,
    output comp_t out_comp
);

    localparam int RECIP_SH = 33;
    localparam int T_W      = 25;
    localparam int M_W      = RECIP_SH + 1;
    localparam int HALF_W   = 17;
    localparam int PP_W     = T_W + HALF_W;
    localparam int PROD_W   = PP_W + HALF_W;

    typedef logic [M_W-1:0] recip_tab_t [256];

    // ceil(2^33 / dd) by long division, evaluated at elaboration
    function automatic logic [M_W-1:0] recip_ceil(input logic [7:0] dv);
        logic [M_W-1:0] q;
        logic [8:0]     r;
        q = '0;
        r = '0;
        for (int i = M_W - 1; i >= 0; i--)
        begin
            r = {r[7:0], (i == RECIP_SH) ? 1'b1 : 1'b0};
            if (r >= {1'b0, dv})
            begin
                r    = r - {1'b0, dv};
                q[i] = 1'b1;
            end
        end
        if (r != 9'd0)
        begin
            q = q + M_W'(1);
        end
        return q;
    endfunction

    function automatic recip_tab_t recip_build();
        recip_tab_t tab;
        tab[0] = '0;
        for (int j = 1; j < 256; j++)
        begin
            tab[j] = recip_ceil(8'(j));
        end
        return tab;
    endfunction

    localparam recip_tab_t RECIP_TAB = recip_build();

    logic vc_reg, vd_reg, ve_reg;
    logic adv_c, adv_d, adv_e;

    logic [T_W-1:0]  t_reg, t_next;
    logic [M_W-1:0]  m_reg;
    logic [8:0]      sum_c_reg, sum_d_reg;
    logic [15:0]     ks_c_reg, ks_d_reg;
    sector_t         sect_c_reg, sect_d_reg;
    logic [PP_W-1:0] pl_reg, pl_next, ph_reg, ph_next;
    logic [PROD_W-1:0] prod;
    comp_t           comp_reg, comp_next;

    assign adv_e    = !ve_reg || out_ready;
    assign adv_d    = !vd_reg || adv_e;
    assign adv_c    = !vc_reg || adv_d;
    assign in_ready = adv_c;

    assign t_next  = {{(T_W-17){1'b0}}, in_hue.ks, 1'b0}
                     * {{(T_W-8){1'b0}}, in_hue.fnum};
    assign pl_next = {{(PP_W-T_W){1'b0}}, t_reg}
                     * {{(PP_W-HALF_W){1'b0}}, m_reg[HALF_W-1:0]};
    assign ph_next = {{(PP_W-T_W){1'b0}}, t_reg}
                     * {{(PP_W-(M_W-HALF_W)){1'b0}}, m_reg[M_W-1:HALF_W]};
    assign prod    = {ph_reg, {HALF_W{1'b0}}} + {{HALF_W{1'b0}}, pl_reg};

    always_comb
    begin
        comp_next.sum    = sum_d_reg;
        comp_next.ks     = ks_d_reg;
        comp_next.sector = sect_d_reg;
        comp_next.part   = prod[RECIP_SH+HALF_W-1:RECIP_SH];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
            ve_reg <= 1'b0;
        end
        else
        begin
            if (adv_c)
            begin
                vc_reg <= in_valid;
            end
            if (adv_d)
            begin
                vd_reg <= vc_reg;
            end
            if (adv_e)
            begin
                ve_reg <= vd_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_c && in_valid)
        begin
            t_reg      <= t_next;
            m_reg      <= RECIP_TAB[in_hue.dd];
            sum_c_reg  <= in_hue.sum;
            ks_c_reg   <= in_hue.ks;
            sect_c_reg <= in_hue.sector;
        end
        if (adv_d && vc_reg)
        begin
            pl_reg     <= pl_next;
            ph_reg     <= ph_next;
            sum_d_reg  <= sum_c_reg;
            ks_d_reg   <= ks_c_reg;
            sect_d_reg <= sect_c_reg;
        end
        if (adv_e && vd_reg)
        begin
            comp_reg <= comp_next;
        end
    end

    assign out_valid = ve_reg;
    assign out_comp  = comp_reg;

endmodule

### rtl/hslsat_rebuild.sv
// one pipeline stage: rebuilds r, g, b from lightness, chroma and sector,
// rounds to nearest and clamps; depends on hslsat_pkg
`timescale 1ns / 1ps

module hslsat_rebuild import hslsat_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  comp_t in_comp,
    output logic  out_valid,
    input  logic  out_ready,
    output pix_t  out_pix
);

    // value is 512 * channel + 256, floor by shift then clamp
    function automatic logic [CHAN_W-1:0] chan_of(input logic signed [18:0] m);
        logic [CHAN_W-1:0] c;
        if (m[18])
        begin
            c = '0;
        end
        else if (m[17])
        begin
            c = '1;
        end
        else
        begin
            c = m[16:9];
        end
        return c;
    endfunction

    logic               vf_reg;
    logic               adv_f;
    pix_t               pix_reg, pix_next;
    logic signed [18:0] m_zero, m_full, m_part;
    logic [CHAN_W-1:0]  c_zero, c_full, c_part;

    assign adv_f    = !vf_reg || out_ready;
    assign in_ready = adv_f;

    always_comb
    begin
        m_zero = $signed({2'b00, in_comp.sum, 8'd0}) - $signed({3'b000, in_comp.ks})
                 + 19'sd256;
        m_full = m_zero + $signed({2'b00, in_comp.ks, 1'b0});
        m_part = m_zero + $signed({2'b00, in_comp.part});
        c_zero = chan_of(m_zero);
        c_full = chan_of(m_full);
        c_part = chan_of(m_part);
        case (in_comp.sector)
            SECT_RY:
            begin
                pix_next.red = c_full;  pix_next.green = c_part; pix_next.blue = c_zero;
            end
            SECT_YG:
            begin
                pix_next.red = c_part;  pix_next.green = c_full; pix_next.blue = c_zero;
            end
            SECT_GC:
            begin
                pix_next.red = c_zero;  pix_next.green = c_full; pix_next.blue = c_part;
            end
            SECT_CB:
            begin
                pix_next.red = c_zero;  pix_next.green = c_part; pix_next.blue = c_full;
            end
            SECT_BM:
            begin
                pix_next.red = c_part;  pix_next.green = c_zero; pix_next.blue = c_full;
            end
            default:
            begin
                pix_next.red = c_full;  pix_next.green = c_zero; pix_next.blue = c_part;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vf_reg <= 1'b0;
        end
        else if (adv_f)
        begin
            vf_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_f && in_valid)
        begin
            pix_reg <= pix_next;
        end
    end

    assign out_valid = vf_reg;
    assign out_pix   = pix_reg;

endmodule

### rtl/hslsat_skid.sv
// output register with a skid word so upstream ready comes from a flop
// depends on hslsat_pkg
`timescale 1ns / 1ps

module hslsat_skid import hslsat_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  pix_t in_pix,
    output logic out_valid,
    input  logic out_ready,
    output pix_t out_pix
);

    logic main_v_reg;
    logic skid_v_reg;
    pix_t main_reg;
    pix_t skid_reg;

    assign in_ready = !skid_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_v_reg <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (out_ready || !main_v_reg)
        begin
            if (skid_v_reg)
            begin
                main_v_reg <= 1'b1;
                skid_v_reg <= 1'b0;
            end
            else
            begin
                main_v_reg <= in_valid;
            end
        end
        else if (in_valid && !skid_v_reg)
        begin
            skid_v_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ready || !main_v_reg)
        begin
            main_reg <= skid_v_reg ? skid_reg : in_pix;
        end
        else if (in_valid && !skid_v_reg)
        begin
            skid_reg <= in_pix;
        end
    end

    assign out_valid = main_v_reg;
    assign out_pix   = main_reg;

endmodule

### rtl/hsl_saturation_set.sv
// top level of the hsl saturation set block: apb register and pipeline
// depends on hslsat_pkg, hslsat_in_if, hslsat_out_if and the hslsat_* stages
`timescale 1ns / 1ps

// Replaces the hsl saturation of each 8-bit bgr pixel with target_saturation
// (apb address 0, 1/256 units, 256 = 1.0, values above 256 act as 256; reset
// 256) while keeping hue and lightness, then rounds and clamps each channel.
// Gray pixels take hue 0 and so turn reddish for a nonzero target. One pixel
// enters per clock unless an output stall backs up to the input; a pixel
// passes seven registers, the six pipeline stages (hue analysis, sector, the
// reciprocal table lookup, two partial products of the reciprocal multiply,
// the partial product sum, rebuild) plus the output register. Stalls on the
// output hold the pipeline without losing or repeating pixels, and empty
// slots are filled while stalled. Write the register only while no pixel is
// in flight.

module hsl_saturation_set import hslsat_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    hslsat_in_if.sink         pix_in,
    hslsat_out_if.source      pix_out
);

    logic [SAT_W-1:0] target_sat_reg;

    pix_t  in_pix;
    pix_t  rb_pix;
    pix_t  out_pix;
    hue_t  hue;
    comp_t comp;

    logic ana_valid, ana_ready;
    logic div_valid, div_ready;
    logic rb_valid, rb_ready;
    logic skid_ready;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_sat_reg <= SAT_ONE;
        end
        else if (psel && penable && pwrite && (paddr[2] == REG_TARGET_SAT))
        begin
            target_sat_reg <= pwdata[SAT_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_TARGET_SAT)
        begin
            prdata = {{(DATA_W-SAT_W){1'b0}}, target_sat_reg};
        end
    end

    assign in_pix.blue  = pix_in.in_blue;
    assign in_pix.green = pix_in.in_green;
    assign in_pix.red   = pix_in.in_red;

    hslsat_analyse u_analyse (
        .clk        (clk),
        .rst_n      (rst_n),
        .target_sat (target_sat_reg),
        .in_valid   (pix_in.valid),
        .in_ready   (pix_in.ready),
        .in_pix     (in_pix),
        .out_valid  (ana_valid),
        .out_ready  (div_ready),
        .out_hue    (hue)
    );

    hslsat_divide u_divide (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (ana_valid),
        .in_ready  (div_ready),
        .in_hue    (hue),
        .out_valid (div_valid),
        .out_ready (ana_ready),
        .out_comp  (comp)
    );

    hslsat_rebuild u_rebuild (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (div_valid),
        .in_ready  (ana_ready),
        .in_comp   (comp),
        .out_valid (rb_valid),
        .out_ready (rb_ready),
        .out_pix   (rb_pix)
    );

    assign rb_ready = skid_ready;

    hslsat_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rb_valid),
        .in_ready  (skid_ready),
        .in_pix    (rb_pix),
        .out_valid (pix_out.valid),
        .out_ready (pix_out.ready),
        .out_pix   (out_pix)
    );

    assign pix_out.out_blue  = out_pix.blue;
    assign pix_out.out_green = out_pix.green;
    assign pix_out.out_red   = out_pix.red;

endmodule
